// ===== src/box_smooth_3d_27pt_core_assert.svh =====
// Assertion macros for the 3x3x3 box smoothing core.
// Used by the back-end module; expects clk and rst_n in scope.
`ifndef BOX_SMOOTH_3D_27PT_CORE_ASSERT_SVH
`define BOX_SMOOTH_3D_27PT_CORE_ASSERT_SVH
// A condition that must hold at every edge outside reset.
`define BSM3D_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A condition that must hold in the cycle after its trigger.
`define BSM3D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/bsm3d_pkg.sv =====
// Shared types and constants for the 3x3x3 box smoothing core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bsm3d_pkg;
  localparam int SAMPLE_BITS = 24;
  localparam int POS_W       = 7;
  localparam int EXT_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int DEF_MAX_X   = 64;
  localparam int DEF_MAX_Y   = 64;
  localparam int DEF_MAX_Z   = 64;
  localparam int Q_DEPTH     = 4;
  localparam int OUT_DEPTH   = 8;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_X_EXTENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_EXTENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_EXTENT = 2'd2;

  // round(2^32 / 27); the average is (S * RECIP_27 + 2^31) >> 32.
  localparam int RECIP_W     = 30;
  localparam logic signed [RECIP_W-1:0] RECIP_27 = 30'sd159072863;
  localparam int ROUND_SHIFT = 32;

  typedef struct packed {
    logic             produce;
    logic             last;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
  } bsm3d_tag_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic [POS_W-1:0]              pos_x;
    logic [POS_W-1:0]              pos_y;
    logic [POS_W-1:0]              pos_z;
    logic                          last;
  } bsm3d_res_t;
endpackage
`default_nettype wire

// ===== src/bsm3d_fifo.sv =====
// Small first-in first-out queue in flip-flops.
// Depends on nothing; DEPTH must be a power of two.
`timescale 1ns / 1ps
`default_nettype none
module bsm3d_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            full,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  assign rdata = mem[rd_ptr_r];
  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
endmodule
`default_nettype wire

// ===== src/bsm3d_front.sv =====
// Front end: extent registers, raster scan counters and word classification.
// Depends on bsm3d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsm3d_front import bsm3d_pkg::*; #(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y,
  parameter int MAX_Z = DEF_MAX_Z
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]                          cfg_index,
  input  wire logic [EXT_W-1:0]                              cfg_data,
  input  wire logic                                          in_valid,
  output logic                                               in_stall,
  input  wire logic                                          q_full,
  output logic                                               q_push,
  output bsm3d_tag_t                                         q_tag,
  output logic [$clog2(MAX_Z+2)-1:0]                         q_line_addr,
  output logic [$clog2((MAX_Y+2)*(MAX_Z+2))-1:0]             q_plane_addr
);
  localparam int CWX = $clog2(MAX_X + 2);
  localparam int CWY = $clog2(MAX_Y + 2);
  localparam int CWZ = $clog2(MAX_Z + 2);
  localparam int PAW = $clog2((MAX_Y + 2) * (MAX_Z + 2));

  logic [EXT_W-1:0] ext_x_r, ext_y_r, ext_z_r;
  logic [CWX-1:0]   ex, x_r, x_nxt;
  logic [CWY-1:0]   ey, y_r, y_nxt;
  logic [CWZ-1:0]   ez, z_r, z_nxt;
  logic [PAW-1:0]   pa_r, pa_nxt;
  logic             accept, z_end, y_end, x_end;

  // Out-of-range extents: zero acts as one, above the maximum acts as it.
  always_comb begin
    if (ext_x_r == '0) ex = CWX'(1);
    else if (int'(ext_x_r) > MAX_X) ex = CWX'(MAX_X);
    else ex = CWX'(ext_x_r);
    if (ext_y_r == '0) ey = CWY'(1);
    else if (int'(ext_y_r) > MAX_Y) ey = CWY'(MAX_Y);
    else ey = CWY'(ext_y_r);
    if (ext_z_r == '0) ez = CWZ'(1);
    else if (int'(ext_z_r) > MAX_Z) ez = CWZ'(MAX_Z);
    else ez = CWZ'(ext_z_r);
  end

  assign accept = in_valid && !q_full;
  assign z_end  = (z_r == ez + CWZ'(1));
  assign y_end  = (y_r == ey + CWY'(1));
  assign x_end  = (x_r == ex + CWX'(1));

  always_comb begin
    x_nxt  = x_r;
    y_nxt  = y_r;
    z_nxt  = z_r;
    pa_nxt = pa_r;
    if (cfg_we) begin
      x_nxt  = '0;
      y_nxt  = '0;
      z_nxt  = '0;
      pa_nxt = '0;
    end else if (accept) begin
      z_nxt  = z_end ? '0 : z_r + CWZ'(1);
      pa_nxt = pa_r + PAW'(1);
      if (z_end) begin
        y_nxt = y_end ? '0 : y_r + CWY'(1);
        if (y_end) begin
          pa_nxt = '0;
          x_nxt  = x_end ? '0 : x_r + CWX'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_x_r <= EXT_W'(64);
      ext_y_r <= EXT_W'(64);
      ext_z_r <= EXT_W'(64);
      x_r     <= '0;
      y_r     <= '0;
      z_r     <= '0;
      pa_r    <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_X_EXTENT) ext_x_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_Y_EXTENT) ext_y_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_Z_EXTENT) ext_z_r <= cfg_data;
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      pa_r <= pa_nxt;
    end
  end

  assign in_stall       = q_full;
  assign q_push         = accept;
  assign q_tag.produce  = (x_r >= CWX'(2)) && (y_r >= CWY'(2)) && (z_r >= CWZ'(2));
  assign q_tag.last     = x_end && y_end && z_end;
  assign q_tag.pos_x    = POS_W'(x_r - CWX'(1));
  assign q_tag.pos_y    = POS_W'(y_r - CWY'(1));
  assign q_tag.pos_z    = POS_W'(z_r - CWZ'(1));
  assign q_line_addr    = z_r;
  assign q_plane_addr   = pa_r;
endmodule
`default_nettype wire

// ===== src/bsm3d_back.sv =====
// Back end: separable 3x3x3 sum over line and plane stores, scaling by 1/27
// and the result queue. Depends on bsm3d_pkg, bsm3d_fifo and the assert header.
`timescale 1ns / 1ps
`default_nettype none
`include "box_smooth_3d_27pt_core_assert.svh"
module bsm3d_back import bsm3d_pkg::*; #(
  parameter int MAX_Y = DEF_MAX_Y,
  parameter int MAX_Z = DEF_MAX_Z
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       q_empty,
  output logic                                            q_pop,
  input  wire logic signed [SAMPLE_BITS-1:0]              q_sample,
  input  wire bsm3d_tag_t                                 q_tag,
  input  wire logic [$clog2(MAX_Z+2)-1:0]                 q_line_addr,
  input  wire logic [$clog2((MAX_Y+2)*(MAX_Z+2))-1:0]     q_plane_addr,
  output logic                                            out_valid,
  input  wire logic                                       out_stall,
  output bsm3d_res_t                                      out_res
);
  localparam int SB          = SAMPLE_BITS;
  localparam int LAW         = $clog2(MAX_Z + 2);
  localparam int PAW         = $clog2((MAX_Y + 2) * (MAX_Z + 2));
  localparam int LINE_DEPTH  = MAX_Z + 2;
  localparam int PLANE_DEPTH = (MAX_Y + 2) * (MAX_Z + 2);
  localparam int S1W         = SB + 2;
  localparam int S2W         = SB + 4;
  localparam int S3W         = SB + 5;
  localparam int PW          = S3W + RECIP_W;
  localparam int OCW         = $clog2(OUT_DEPTH + 1);
  localparam int CRW         = OCW + 1;

  // Each line entry holds the z-sums of the two previous rows, each plane
  // entry the yz-sums of the two previous planes, newest in the low half.
  logic [2*S1W-1:0] line_mem  [LINE_DEPTH];
  logic [2*S2W-1:0] plane_mem [PLANE_DEPTH];

  logic signed [SB-1:0]  d1_r, d2_r;
  logic signed [S1W-1:0] s1_r;
  logic [2*S1W-1:0]      lrd_r;
  logic signed [S2W-1:0] s2, s2_r;
  logic [2*S2W-1:0]      prd_r;
  logic signed [S3W-1:0] s3, s3_r;
  logic signed [PW-1:0]  prod_r, rnd;
  logic                  v1_r, v2_r, v3_r, v4_r;
  bsm3d_tag_t            tag1_r, tag2_r, tag3_r, tag4_r;
  logic [LAW-1:0]        la1_r;
  logic [PAW-1:0]        pa1_r, pa2_r;
  logic [2:0]            inflight;
  logic [OCW-1:0]        ocnt;
  logic                  opush, opop, ofull, oempty;
  bsm3d_res_t            ores;

  // Never more words in the pipe and the result queue than it can hold,
  // so the pipe itself never stalls.
  assign inflight = 3'(v1_r) + 3'(v2_r) + 3'(v3_r) + 3'(v4_r);
  assign q_pop    = !q_empty && ((CRW'(inflight) + CRW'(ocnt)) < CRW'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= q_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign s2 = S2W'(s1_r) + S2W'($signed(lrd_r[S1W-1:0]))
            + S2W'($signed(lrd_r[2*S1W-1:S1W]));
  assign s3 = S3W'(s2_r) + S3W'($signed(prd_r[S2W-1:0]))
            + S3W'($signed(prd_r[2*S2W-1:S2W]));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      d1_r   <= q_sample;
      d2_r   <= d1_r;
      s1_r   <= S1W'(q_sample) + S1W'(d1_r) + S1W'(d2_r);
      lrd_r  <= line_mem[q_line_addr];
      tag1_r <= q_tag;
      la1_r  <= q_line_addr;
      pa1_r  <= q_plane_addr;
    end
    if (v1_r) begin
      line_mem[la1_r] <= {lrd_r[S1W-1:0], s1_r};
      s2_r            <= s2;
      prd_r           <= plane_mem[pa1_r];
      tag2_r          <= tag1_r;
      pa2_r           <= pa1_r;
    end
    if (v2_r) begin
      plane_mem[pa2_r] <= {prd_r[S2W-1:0], s2_r};
      s3_r             <= s3;
      tag3_r           <= tag2_r;
    end
    if (v3_r) begin
      prod_r <= PW'(s3_r) * PW'(RECIP_27);
      tag4_r <= tag3_r;
    end
  end

  assign rnd            = prod_r + (PW'(1) <<< (ROUND_SHIFT - 1));
  assign opush          = v4_r && tag4_r.produce;
  assign ores.smoothed  = rnd[ROUND_SHIFT +: SB];
  assign ores.pos_x     = tag4_r.pos_x;
  assign ores.pos_y     = tag4_r.pos_y;
  assign ores.pos_z     = tag4_r.pos_z;
  assign ores.last      = tag4_r.last;
  assign opop           = !oempty && !out_stall;

  bsm3d_fifo #(
    .WIDTH ($bits(bsm3d_res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (opush),
    .wdata (ores),
    .pop   (opop),
    .rdata (out_res),
    .full  (ofull),
    .empty (oempty),
    .count (ocnt)
  );

  assign out_valid = !oempty;

  `BSM3D_ASSERT_ALWAYS(a_credit_bound, (CRW'(inflight) + CRW'(ocnt)) <= CRW'(OUT_DEPTH), "pipe and result queue over capacity")
  `BSM3D_ASSERT_ALWAYS(a_no_push_full, !(opush && ofull && !opop), "result pushed into full queue")
  `BSM3D_ASSERT_NEXT(a_pop_enters, q_pop, v1_r, "popped word missing from first stage")
endmodule
`default_nettype wire

// ===== src/box_smooth_3d_27pt_core.sv =====
// 3x3x3 box smoothing core: top level joining front end, queue and back end.
// Depends on bsm3d_pkg, bsm3d_front, bsm3d_fifo and bsm3d_back.
//
// Usage. Grid samples, halo included, stream in on the in_ channel in raster
// order with z fastest and x slowest; a word moves when in_valid is high and
// in_stall is low. For each interior point one result word leaves on the
// out_ channel: the rounded 27-point average and its interior position,
// with out_last_point marking the final point of the grid. Halo samples
// give no result. The extents are written through cfg_we/cfg_index/cfg_data
// while the core is idle; every write restarts the frame at the halo corner.
// Throughput is one sample per cycle while in_stall is low. A result is offered
// on the out_ port once the sample that completes its neighbourhood has passed
// through the input queue, the sum pipeline, which reads a line store and a
// plane store of partial sums, and the multiply, after which the word waits in
// the result queue until the receiver takes it.
// Reset clears the scan position and sets all extents to 64; the stores need
// no clearing because only entries written in the current frame are read.
// A stall on the result side fills the result queue, then the input queue,
// after which in_stall rises; no word is lost.
`timescale 1ns / 1ps
`default_nettype none
module box_smooth_3d_27pt_core import bsm3d_pkg::*; #(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y,
  parameter int MAX_Z = DEF_MAX_Z
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [EXT_W-1:0]              cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_smoothed,
  output logic [POS_W-1:0]                   out_pos_x,
  output logic [POS_W-1:0]                   out_pos_y,
  output logic [POS_W-1:0]                   out_pos_z,
  output logic                               out_last_point
);
  localparam int LAW = $clog2(MAX_Z + 2);
  localparam int PAW = $clog2((MAX_Y + 2) * (MAX_Z + 2));
  localparam int QW  = SAMPLE_BITS + $bits(bsm3d_tag_t) + LAW + PAW;

  // Queue word: sample, classification tag, line and plane addresses.
  logic                   q_push, q_pop, q_full, q_empty;
  bsm3d_tag_t             f_tag, b_tag;
  logic [LAW-1:0]         f_la, b_la;
  logic [PAW-1:0]         f_pa, b_pa;
  logic [SAMPLE_BITS-1:0] b_sample;
  logic [QW-1:0]          q_rdata;
  logic [$clog2(Q_DEPTH+1)-1:0] q_count;
  bsm3d_res_t             res;

  bsm3d_front #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_tag        (f_tag),
    .q_line_addr  (f_la),
    .q_plane_addr (f_pa)
  );

  bsm3d_fifo #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({in_sample, f_tag, f_la, f_pa}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty),
    .count (q_count)
  );

  assign {b_sample, b_tag, b_la, b_pa} = q_rdata;

  bsm3d_back #(
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty || (q_count == '0)),
    .q_pop        (q_pop),
    .q_sample     ($signed(b_sample)),
    .q_tag        (b_tag),
    .q_line_addr  (b_la),
    .q_plane_addr (b_pa),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (res)
  );

  assign out_smoothed   = res.smoothed;
  assign out_pos_x      = res.pos_x;
  assign out_pos_y      = res.pos_y;
  assign out_pos_z      = res.pos_z;
  assign out_last_point = res.last;
endmodule
`default_nettype wire

// ===== bench/box_smooth_3d_27pt_core_tb.sv =====
// Self-checking bench for the 3x3x3 box smoothing core: streams halo grids of
// many shapes, predicts every smoothed word and compares it field by field.
// Depends on bsm3d_pkg and box_smooth_3d_27pt_core.
`timescale 1ns / 1ps
`default_nettype none
module box_smooth_3d_27pt_core_tb;
  import bsm3d_pkg::*;

  localparam int GRID_MAX  = DEF_MAX_X + 2;
  localparam int SETTLE    = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int ITEM_GOAL = 1850;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int { SMP_RANDOM, SMP_MAX, SMP_MIN, SMP_NARROW, SMP_EXTREMES } smp_mode_t;

  // Tracks the scan position and the last three x-planes, and keeps the
  // averages that are still owed by the core.
  class smooth_scoreboard;
    int               plane[3][GRID_MAX][GRID_MAX];
    int unsigned      extent[3];
    int unsigned      sx, sy, sz;
    bsm3d_res_t       owed[$];
    int               errors;

    function new();
      extent = '{64, 64, 64};
      sx = 0; sy = 0; sz = 0;
      errors = 0;
    endfunction

    // Any write, the spare index included, restarts the frame.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [EXT_W-1:0] val);
      if (idx != CFG_SPARE) extent[idx] = val;
      sx = 0; sy = 0; sz = 0;
    endfunction

    function int unsigned clamped(int i);
      if (extent[i] < 1) return 1;
      if (extent[i] > 64) return 64;
      return extent[i];
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] s);
      int unsigned ex, ey, ez;
      longint sum, n, q;
      bsm3d_res_t r;
      ex = clamped(0); ey = clamped(1); ez = clamped(2);
      plane[sx % 3][sy][sz] = s;
      if (sx >= 2 && sy >= 2 && sz >= 2) begin
        sum = 0;
        for (int dx = 0; dx < 3; dx++)
          for (int dy = 0; dy < 3; dy++)
            for (int dz = 0; dz < 3; dz++)
              sum += plane[(sx - dx) % 3][sy - dy][sz - dz];
        // Round to nearest: floor((2S + 27) / 54).
        n = 2 * sum + 27;
        q = (n >= 0) ? n / 54 : -((-n + 53) / 54);
        r.smoothed = q[SAMPLE_BITS-1:0];
        r.pos_x = POS_W'(sx - 1);
        r.pos_y = POS_W'(sy - 1);
        r.pos_z = POS_W'(sz - 1);
        r.last = (sx - 1 == ex) && (sy - 1 == ey) && (sz - 1 == ez);
        owed.push_back(r);
      end
      sz++;
      if (sz >= ez + 2) begin
        sz = 0; sy++;
        if (sy >= ey + 2) begin
          sy = 0; sx++;
          if (sx >= ex + 2) sx = 0;
        end
      end
    endfunction

    function void check_result(bsm3d_res_t got);
      bsm3d_res_t want;
      if (owed.size() == 0) begin
        $error("unexpected word: smoothed %0d at (%0d,%0d,%0d)", got.smoothed,
               got.pos_x, got.pos_y, got.pos_z);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.smoothed !== want.smoothed) begin
        $error("smoothed: expected %0d, got %0d", want.smoothed, got.smoothed);
        errors++;
      end
      if (got.pos_x !== want.pos_x) begin
        $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
        errors++;
      end
      if (got.pos_y !== want.pos_y) begin
        $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
        errors++;
      end
      if (got.pos_z !== want.pos_z) begin
        $error("pos_z: expected %0d, got %0d", want.pos_z, got.pos_z);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_point: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [EXT_W-1:0]              cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] out_smoothed;
  logic [POS_W-1:0]              out_pos_x;
  logic [POS_W-1:0]              out_pos_y;
  logic [POS_W-1:0]              out_pos_z;
  logic                          out_last_point;

  smooth_scoreboard sb = new();
  int  words_sent;
  int  words_taken;
  int  idle_cycles;

  box_smooth_3d_27pt_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_smoothed(out_smoothed),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_last_point(out_last_point)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Both channels are observed at the edge itself, before the core's own
  // registers update, so each accepted word is seen exactly once.
  always @(posedge clk) begin
    bsm3d_res_t got;
    if (rst_n && in_valid && !in_stall) begin
      sb.note_sample(in_sample);
      words_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      got.smoothed = out_smoothed;
      got.pos_x = out_pos_x;
      got.pos_y = out_pos_y;
      got.pos_z = out_pos_z;
      got.last = out_last_point;
      sb.check_result(got);
    end
  end

  // The watchdog counts cycles in which no word moves on any port.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL box_smooth_3d_27pt_core");
        $finish;
      end
    end
  end

  // The receiver switches to a random stall pattern now and then. Once, after a
  // few hundred words are in and while the sender is offering, it holds off
  // for a long stretch so that both internal queues fill and the core stalls
  // its input.
  initial begin
    int unsigned pattern;
    int          hold_left;
    bit          held;
    pattern = 0;
    hold_left = 0;
    held = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_taken >= 600 && in_valid) begin
        held = 1;
        hold_left = 400;
      end
      if ($urandom_range(0, 63) == 0) pattern = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (pattern)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ($urandom_range(0, 9) < 8);
          default: out_stall <= ($urandom_range(0, 7) < 2) ? 1'b1 : 1'b0;
        endcase
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(smp_mode_t mode);
    case (mode)
      SMP_MAX:      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      SMP_MIN:      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      SMP_NARROW:   return SAMPLE_BITS'($signed($urandom_range(0, 200)) - 100);
      SMP_EXTREMES: return $urandom_range(0, 1) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                                : {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      default:      return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Offers count words in bursts of random length with random gaps between.
  task automatic send_words(int count, smp_mode_t mode);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_valid <= 1'b1;
      in_sample <= pick_sample(mode);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      burst_left--;
      words_sent++;
    end
    in_valid <= 1'b0;
  endtask

  // Waits until every owed word has arrived, then lets the pipeline settle,
  // since a halo sample may still be in flight with nothing owed for it.
  task automatic wait_drained();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EXT_W-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(int ex, int ey, int ez);
    write_reg(CFG_X_EXTENT, EXT_W'(ex));
    write_reg(CFG_Y_EXTENT, EXT_W'(ey));
    write_reg(CFG_Z_EXTENT, EXT_W'(ez));
  endtask

  function automatic int frame_words();
    return (sb.clamped(0) + 2) * (sb.clamped(1) + 2) * (sb.clamped(2) + 2);
  endfunction

  initial begin
    int        frame;
    int        pick;
    int        n;
    smp_mode_t mode;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_sample = '0;
    words_sent = 0;
    words_taken = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A few halo words at the reset extents, then the
    // smallest grid filled with the largest and smallest samples, a frame
    // cut short by a write to the spare index, and clamped extents.
    send_words(8, SMP_RANDOM);
    set_grid(1, 1, 1);
    send_words(27, SMP_MAX);
    send_words(27, SMP_MIN);
    send_words(13, SMP_EXTREMES);
    write_reg(CFG_SPARE, 7'd5);
    send_words(27, SMP_EXTREMES);
    set_grid(0, 127, 1);
    send_words(frame_words(), SMP_RANDOM);

    // Random part: mostly whole frames of small grids, now and then one
    // long axis, a truncated frame or a bare restart. The last batch is cut
    // to the item goal.
    while (words_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        case ($urandom_range(0, 2))
          0: set_grid(64, 1, 1);
          1: set_grid(1, $urandom_range(0, 1) ? 64 : 100, 1);
          default: set_grid(1, 1, $urandom_range(0, 1) ? 64 : 0);
        endcase
      end else if (pick == 1) begin
        write_reg(CFG_SPARE, EXT_W'($urandom));
      end else begin
        set_grid($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4));
      end
      frame = frame_words();
      case ($urandom_range(0, 5))
        0: mode = SMP_NARROW;
        1: mode = SMP_EXTREMES;
        default: mode = SMP_RANDOM;
      endcase
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, frame - 1);
      end else begin
        n = frame * ((frame > 200) ? 1 : $urandom_range(1, 2));
      end
      if (n > ITEM_GOAL - words_sent) n = ITEM_GOAL - words_sent;
      send_words(n, mode);
      // Sometimes the sender pauses until every owed word has come back.
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("PASS box_smooth_3d_27pt_core");
    end else begin
      $display("FAIL box_smooth_3d_27pt_core");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/bsm3d_pkg.sv
src/bsm3d_fifo.sv
src/bsm3d_front.sv
src/bsm3d_back.sv
src/box_smooth_3d_27pt_core.sv
bench/box_smooth_3d_27pt_core_tb.sv
